/* sv/gfalu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gfalu_pkg;

  localparam int ELEM_BITS_DEF = 8;
  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MUL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INV = 2'd2;

  // x^8 + x^4 + x^3 + x + 1
  localparam logic [8:0] MODULUS_RESET = 9'h11B;

  typedef struct packed {
    logic load;       // capture operands and restart the candidate counter
    logic issue;      // push one candidate into the multiplier pipeline
    logic flush;      // drop everything in flight in the pipeline
    logic set_imm;    // result register takes the direct answer
    logic take_pipe;  // result register takes the pipeline output
    logic out_load;   // output register takes the result register
  } fa_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              mod_bad;
    logic              a_zero;
    logic              exhausted;
    logic              p1v;
    logic              p2v;
    logic              p3v;
    logic              match;
  } fa_stat_t;

endpackage

`default_nettype wire

/* sv/gfalu_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module gfalu_dpath #(
  parameter int ELEM_BITS = gfalu_pkg::ELEM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ELEM_BITS:0]            cfg_data,
  input  logic [gfalu_pkg::FUNC_W-1:0]  func,
  input  logic [ELEM_BITS-1:0]          operand_a,
  input  logic [ELEM_BITS-1:0]          operand_b,
  input  gfalu_pkg::fa_cmd_t            cmd,
  output gfalu_pkg::fa_stat_t           stat,
  output logic [ELEM_BITS-1:0]          result,
  output logic                          found,
  output logic                          bad_modulus
);
  import gfalu_pkg::*;

  localparam int MW = ELEM_BITS + 1;
  localparam int PW = 2 * ELEM_BITS - 1;
  localparam int DW = $clog2(ELEM_BITS + 1);
  localparam logic [MW-1:0] RST_MOD = MW'(MODULUS_RESET);

  function automatic logic [DW-1:0] deg_of(input logic [MW-1:0] v);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i < MW; i++) begin
      if (v[i]) d = DW'(i);
    end
    return d;
  endfunction

  // Shift the polynomial so that its leading term sits at x^ELEM_BITS.
  function automatic logic [MW-1:0] norm_of(input logic [MW-1:0] v);
    return v << (ELEM_BITS - int'(deg_of(v)));
  endfunction

  function automatic logic is_bad(input logic [MW-1:0] v);
    return (v[MW-1:1] == '0);
  endfunction

  // Modulus, kept in the form the reduction stages use.
  logic [MW-1:0]        mod_norm;
  logic [DW-1:0]        mod_deg;
  logic                 mod_bad;

  logic [FUNC_W-1:0]    func_reg;
  logic [ELEM_BITS-1:0] a_reg;
  logic [ELEM_BITS-1:0] b_reg;
  logic [MW-1:0]        cnt;

  logic                 p1v, p2v, p3v;
  logic [PW-1:0]        p1_prod;
  logic [ELEM_BITS-1:0] p1_cand, p2_rem, p2_cand, p3_prod, p3_cand;

  logic [ELEM_BITS-1:0] res_q;
  logic                 found_q, bad_q;

  logic [ELEM_BITS-1:0] cand_in;
  logic [PW-1:0]        prod_c;
  logic [PW-1:0]        r1;
  logic [ELEM_BITS-1:0] r2;
  logic [MW-1:0]        nshift;
  logic                 match;
  logic [ELEM_BITS-1:0] imm_res, pipe_res;
  logic                 imm_found, imm_bad;

  // Stage 1: carry-less product of operand_a and the candidate.
  always_comb begin
    cand_in = (func_reg == FUNC_MUL) ? b_reg : cnt[ELEM_BITS-1:0];
    prod_c  = '0;
    for (int i = 0; i < ELEM_BITS; i++) begin
      if (cand_in[i]) prod_c = prod_c ^ (PW'(a_reg) << i);
    end
  end

  // Stage 2: clear the high half, which always lies at or above the modulus degree.
  always_comb begin
    r1 = p1_prod;
    for (int k = PW - 1; k >= ELEM_BITS; k--) begin
      if (r1[k]) r1 = r1 ^ (PW'(mod_norm) << (k - ELEM_BITS));
    end
  end

  // Stage 3: clear the low half down to the modulus degree.
  always_comb begin
    r2     = p2_rem;
    nshift = '0;
    for (int k = ELEM_BITS - 1; k >= 1; k--) begin
      nshift = mod_norm >> (ELEM_BITS - k);
      if (r2[k] && (DW'(k) >= mod_deg)) r2 = r2 ^ nshift[ELEM_BITS-1:0];
    end
  end

  assign match = p3v && (p3_prod == ELEM_BITS'(1));

  always_comb begin
    imm_res   = '0;
    imm_found = 1'b0;
    imm_bad   = 1'b0;
    unique case (func_reg) inside
      FUNC_ADD: begin
        imm_res   = a_reg ^ b_reg;
        imm_found = 1'b1;
      end
      FUNC_MUL, FUNC_INV: begin
        imm_bad = mod_bad;
      end
      default: begin
        imm_res = '0;
      end
    endcase
    pipe_res = (func_reg == FUNC_MUL) ? p3_prod : p3_cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_norm <= norm_of(RST_MOD);
      mod_deg  <= deg_of(RST_MOD);
      mod_bad  <= is_bad(RST_MOD);
      p1v      <= 1'b0;
      p2v      <= 1'b0;
      p3v      <= 1'b0;
      cnt      <= '0;
    end else begin
      if (cfg_we) begin
        mod_norm <= norm_of(cfg_data);
        mod_deg  <= deg_of(cfg_data);
        mod_bad  <= is_bad(cfg_data);
      end
      if (cmd.flush) begin
        p1v <= 1'b0;
        p2v <= 1'b0;
        p3v <= 1'b0;
      end else begin
        p1v <= cmd.issue;
        p2v <= p1v;
        p3v <= p2v;
      end
      if (cmd.load) begin
        cnt <= MW'(1);
      end else if (cmd.issue) begin
        cnt <= cnt + MW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_reg <= func;
      a_reg    <= operand_a;
      b_reg    <= operand_b;
    end
    p1_prod <= prod_c;
    p1_cand <= cand_in;
    p2_rem  <= r1[ELEM_BITS-1:0];
    p2_cand <= p1_cand;
    p3_prod <= r2;
    p3_cand <= p2_cand;
    if (cmd.set_imm) begin
      res_q   <= imm_res;
      found_q <= imm_found;
      bad_q   <= imm_bad;
    end else if (cmd.take_pipe) begin
      res_q   <= pipe_res;
      found_q <= 1'b1;
      bad_q   <= 1'b0;
    end
    if (cmd.out_load) begin
      result      <= res_q;
      found       <= found_q;
      bad_modulus <= bad_q;
    end
  end

  always_comb begin
    stat.func      = func_reg;
    stat.mod_bad   = mod_bad;
    stat.a_zero    = (a_reg == '0);
    stat.exhausted = cnt[ELEM_BITS];
    stat.p1v       = p1v;
    stat.p2v       = p2v;
    stat.p3v       = p3v;
    stat.match     = match;
  end

endmodule

`default_nettype wire

/* sv/gfalu_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module gfalu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gfalu_pkg::fa_cmd_t   cmd,
  input  gfalu_pkg::fa_stat_t  stat
);
  import gfalu_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_RUN    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.func == FUNC_MUL && !stat.mod_bad) begin
          cmd.issue  = 1'b1;
          state_next = S_RUN;
        end else if (stat.func == FUNC_INV && !stat.mod_bad && !stat.a_zero) begin
          state_next = S_RUN;
        end else begin
          cmd.set_imm = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_RUN: begin
        if (stat.func == FUNC_MUL) begin
          if (stat.p3v) begin
            cmd.take_pipe = 1'b1;
            cmd.flush     = 1'b1;
            state_next    = S_FINISH;
          end
        end else if (stat.match) begin
          cmd.take_pipe = 1'b1;
          cmd.flush     = 1'b1;
          state_next    = S_FINISH;
        end else if (!stat.exhausted) begin
          cmd.issue = 1'b1;
        end else if (!stat.p1v && !stat.p2v) begin
          cmd.set_imm = 1'b1;
          cmd.flush   = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/gf2m_field_alu_core.sv */
// Transactions are taken one at a time: a new operation is accepted only after the last
// result has been moved to the output register. The inverse search pushes one candidate
// per cycle through a three-stage field multiplier and ends without an inverse once every
// candidate has been tried.
// Synchronous active-high reset empties the block and sets the modulus to 0x11B.
`timescale 1ns / 1ps
`default_nettype none

module gf2m_field_alu_core #(
  parameter int ELEM_BITS = gfalu_pkg::ELEM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Operation channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gfalu_pkg::FUNC_W-1:0]  func,
  input  logic [ELEM_BITS-1:0]          operand_a,
  input  logic [ELEM_BITS-1:0]          operand_b,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ELEM_BITS-1:0]          result,
  output logic                          found,
  output logic                          bad_modulus,
  // Modulus write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ELEM_BITS:0]            cfg_data
);
  import gfalu_pkg::*;

  fa_cmd_t  cmd;
  fa_stat_t stat;

  // The modulus register always takes a write; the user writes it only while idle.
  assign cfg_ready = 1'b1;

  // The controller sequences one transaction at a time. Add and every error case are
  // answered directly. Multiply sends operand_b once through the multiplier pipeline,
  // while inverse sends the candidates 1, 2, ... in order and stops at the first one
  // whose reduced product with operand_a is 1, which is then the smallest inverse.
  gfalu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the modulus, the captured operands, the candidate counter, the
  // pipelined multiplier (product, upper reduction, lower reduction) and an output
  // register, so a finished result can wait while the next transaction is computed.
  gfalu_dpath #(
    .ELEM_BITS (ELEM_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .func        (func),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result),
    .found       (found),
    .bad_modulus (bad_modulus)
  );

  // Only one transaction is in the engine at a time.
  a_one_at_a_time : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while the engine was busy");

  // A valid result and a modulus error exclude each other.
  a_found_not_bad : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && bad_modulus))
    else $error("result flagged both found and bad modulus");

  // A result without found set reads as zero.
  a_miss_is_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> result == '0)
    else $error("nonzero result without found");

  // The pipeline is never flushed while a candidate is issued.
  a_flush_issue : assert property (@(posedge clk) disable iff (rst)
    !(cmd.flush && cmd.issue))
    else $error("pipeline flush collided with an issue");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the GF(2^m) field unit. It covers add, reduced multiply and
// inverse search over several reducing polynomials, including the ones that are
// too small to reduce by. A small class keeps its own copy of the modulus and predicts
// every outcome. The monitor pairs each result transaction with the oldest prediction.
module tb_top;
  import gfalu_pkg::*;

  localparam int EW = ELEM_BITS_DEF;

  // The selector value that names no operation. The block answers it with all zeros.
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  // Longest stretch of cycles with no transaction on any channel before the run is
  // declared hung. The slowest case is a failed inverse search followed by a receiver
  // stall, and the limit leaves a wide margin over that.
  localparam int HANG_LIMIT = 2000;
  // Cycles to watch the result port after the last expected transaction. This is
  // longer than the slowest inverse search, so a late extra result would still show.
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic [EW-1:0] value;
    logic          found;
    logic          bad;
  } gf_outcome_t;

  // Holds the modulus copy and the queue of predicted outcomes, in order of issue.
  class gf_outcome_tracker;
    logic [EW:0]  modulus;
    gf_outcome_t  outcome_q[$];
    int           errors;
    int           op_count[4];
    int           found_seen;
    int           bad_seen;

    function new();
      modulus = MODULUS_RESET;
      errors = 0;
      found_seen = 0;
      bad_seen = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    static function automatic int degree_of(logic [15:0] v);
      int d;
      d = -1;
      for (int i = 0; i < 16; i++) begin
        if (v[i]) d = i;
      end
      return d;
    endfunction

    // Carry-less product, then reduction from the top bit down to the modulus degree.
    static function automatic logic [15:0] field_product(logic [EW-1:0] x, logic [EW-1:0] y,
                                                         logic [EW:0] m);
      logic [15:0] acc;
      logic [15:0] mw;
      int          dm;
      acc = '0;
      mw = 16'(m);
      for (int i = 0; i < EW; i++) begin
        if (y[i]) acc ^= 16'(x) << i;
      end
      dm = degree_of(mw);
      for (int bitpos = 2 * EW - 2; bitpos >= dm; bitpos--) begin
        if (acc[bitpos]) acc ^= mw << (bitpos - dm);
      end
      return acc;
    endfunction

    function automatic gf_outcome_t field_outcome(logic [FUNC_W-1:0] f, logic [EW-1:0] a,
                                                  logic [EW-1:0] b);
      gf_outcome_t o;
      o.value = '0;
      o.found = 1'b0;
      o.bad = 1'b0;
      if (f == FUNC_ADD) begin
        o.value = a ^ b;
        o.found = 1'b1;
      end else if (f == FUNC_MUL || f == FUNC_INV) begin
        if (modulus < 2) begin
          o.bad = 1'b1;
        end else if (f == FUNC_MUL) begin
          o.value = EW'(field_product(a, b, modulus));
          o.found = 1'b1;
        end else if (a != 0) begin
          for (int c = 1; c < (1 << EW); c++) begin
            if (field_product(a, EW'(c), modulus) == 16'd1) begin
              o.value = EW'(c);
              o.found = 1'b1;
              break;
            end
          end
        end
      end
      return o;
    endfunction

    function void log_operation(logic [FUNC_W-1:0] f, logic [EW-1:0] a, logic [EW-1:0] b);
      outcome_q.push_back(field_outcome(f, a, b));
      op_count[f]++;
    endfunction

    function void match_result(logic [EW-1:0] value, logic found, logic bad);
      gf_outcome_t e;
      if (found) found_seen++;
      if (bad) bad_seen++;
      if (outcome_q.size() == 0) begin
        $error("result transaction arrived with no operation outstanding");
        errors++;
        return;
      end
      e = outcome_q.pop_front();
      if (value !== e.value) begin
        $error("result mismatch: expected %0h, actual %0h", e.value, value);
        errors++;
      end
      if (found !== e.found) begin
        $error("found mismatch: expected %0b, actual %0b", e.found, found);
        errors++;
      end
      if (bad !== e.bad) begin
        $error("bad_modulus mismatch: expected %0b, actual %0b", e.bad, bad);
        errors++;
      end
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] func = FUNC_ADD;
  logic [EW-1:0]     operand_a = '0;
  logic [EW-1:0]     operand_b = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [EW-1:0]     result;
  logic              found;
  logic              bad_modulus;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [EW:0]       cfg_data = '0;

  gf_outcome_tracker book = new();

  // When set, the sender inserts random gaps and the receiver stalls at random.
  bit jitter = 1'b0;
  int moduli_written = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  gf2m_field_alu_core #(
    .ELEM_BITS(EW)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result),
    .found      (found),
    .bad_modulus(bad_modulus),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Every result transaction is checked at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) book.match_result(result, found, bad_modulus);
  end

  // Watchdog: it counts cycles with no transaction on any of the three channels.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               HANG_LIMIT, book.pending());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: while jitter is on, ready drops at random now and then.
  // Otherwise it is held high.
  initial begin
    forever begin
      @(negedge clk);
      if (jitter && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Presents one operation and returns at the edge where it is accepted. Valid stays
  // high afterward, so the caller must follow with another operation, a gap or a release.
  task automatic send_op(logic [FUNC_W-1:0] f, logic [EW-1:0] a, logic [EW-1:0] b);
    @(negedge clk);
    in_valid <= 1'b1;
    func <= f;
    operand_a <= a;
    operand_b <= b;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    book.log_operation(f, a, b);
  endtask

  task automatic hold_off(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Lowers valid and waits until every outstanding operation has produced its result.
  // Each operation gives exactly one result, so an empty queue means the block is idle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(logic [EW:0] m);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    book.modulus = m;
    moduli_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Operands sometimes come from a few corner values, most often from the full range.
  function automatic logic [EW-1:0] pick_element();
    logic [EW-1:0] corners[4];
    corners = '{8'h00, 8'hFF, 8'h01, 8'h80};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 3)];
    return EW'($urandom_range(0, (1 << EW) - 1));
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 15);
    if (r < 5) return FUNC_ADD;
    if (r < 10) return FUNC_MUL;
    if (r < 15) return FUNC_INV;
    return FUNC_NONE;
  endfunction

  task automatic random_batch(int count);
    for (int i = 0; i < count; i++) begin
      if (jitter && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 4));
      send_op(pick_func(), pick_element(), pick_element());
    end
  endtask

  logic [EW:0] phase_moduli[11];
  int          batch;

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset polynomial x^8+x^4+x^3+x+1.
    send_op(FUNC_ADD, 8'h00, 8'hFF);
    send_op(FUNC_ADD, 8'hFF, 8'hFF);
    send_op(FUNC_MUL, 8'hFF, 8'hFF);
    send_op(FUNC_MUL, 8'h80, 8'h02);
    send_op(FUNC_MUL, 8'h00, 8'hFF);
    send_op(FUNC_MUL, 8'h01, 8'hA5);
    send_op(FUNC_INV, 8'h00, 8'hFF);   // zero has no inverse
    send_op(FUNC_INV, 8'h01, 8'h00);
    send_op(FUNC_INV, 8'h53, 8'h00);
    send_op(FUNC_INV, 8'hFF, 8'h5A);
    send_op(FUNC_NONE, 8'hFF, 8'hFF);  // unused selector answers all zeros

    // A zero polynomial: multiply and inverse flag the modulus, add is unaffected.
    write_modulus(9'h000);
    send_op(FUNC_MUL, 8'h03, 8'h07);
    send_op(FUNC_INV, 8'h05, 8'h00);
    send_op(FUNC_ADD, 8'h12, 8'h34);
    write_modulus(9'h001);
    send_op(FUNC_INV, 8'h01, 8'h00);
    send_op(FUNC_MUL, 8'hFF, 8'hFF);

    // All coefficients set: reducible, so some operands have no inverse at all.
    write_modulus(9'h1FF);
    send_op(FUNC_MUL, 8'hFF, 8'h80);
    send_op(FUNC_INV, 8'h03, 8'h00);

    // Degree one: operands far above the modulus degree still reduce to a constant.
    write_modulus(9'h002);
    send_op(FUNC_MUL, 8'hFF, 8'hFF);
    send_op(FUNC_INV, 8'hFE, 8'h00);

    // x^8 alone: even elements share a factor with it, odd ones are invertible.
    write_modulus(9'h100);
    send_op(FUNC_INV, 8'h02, 8'h00);
    send_op(FUNC_INV, 8'hFF, 8'h00);

    // Random part. Every third batch and the final one run with smooth traffic, the others
    // with jitter. The final batch runs under the reset polynomial with no idling on either side.
    phase_moduli = '{9'h11B, 9'h1FF, 9'h000, 9'h013, 9'h11D, 9'h001, 9'h007, 9'h003,
                     EW'(0) | 9'($urandom_range(0, 511)), 9'($urandom_range(2, 511)),
                     9'h11B};
    foreach (phase_moduli[p]) begin
      write_modulus(phase_moduli[p]);
      jitter = (p % 3 != 2) && (p != 10);
      batch = (p == 10) ? 140 : 105;
      random_batch(batch);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.pending() != 0) begin
      $error("%0d results never arrived", book.pending());
      book.errors++;
    end

    $display("Ran %0d add, %0d multiply, %0d inverse and %0d unused-selector operations",
             book.op_count[FUNC_ADD], book.op_count[FUNC_MUL], book.op_count[FUNC_INV],
             book.op_count[FUNC_NONE]);
    $display("across %0d polynomial writes; %0d results had found set, %0d flagged the modulus",
             moduli_written, book.found_seen, book.bad_seen);
    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
